[design/ssi_pkg.sv]
// Package for the sorted key set: request and response field layout,
// operation and status codes, and the controller state type.
// No dependencies.
package ssi_pkg;

   localparam int MODE_W      = 2;
   localparam int KEY_FIELD_W = 16;
   localparam int POS_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int VALUE_W     = 16;
   localparam int COUNT_W     = 5;
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = MODE_W;
   localparam int RSP_DATA_W  = 24;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SHIFT = 7'b0000100,
      S_PUT   = 7'b0001000,
      S_READ  = 7'b0010000,
      S_FETCH = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
      logic                hit;
   } rsp_type;

endpackage

[design/ssi_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ssi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/sorted_set_insert_lookup.sv]
// Sorted key set controller; keys live in one ssi_ram instance.
// Depends on ssi_pkg and ssi_ram.
//
// Holds up to CAPACITY distinct keys in ascending order in a single-port-pair
// RAM and serves one request at a time. A request takes the store's read port
// through the keys in order. An insert walks up to the insertion point and then
// moves every larger key up by one. Keys only move while the set has room. The
// next request is taken as soon as the previous response sits in the output
// register, even while that response waits for rsp_tready. Reset empties the
// set at once; no clearing pass runs.
module sorted_set_insert_lookup
   import ssi_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key [15:0], position [19:16], zero [23:20]
   input  logic [REQ_USER_W-1:0] req_tuser,  // mode [1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // hit [0], status [2:1], read_value [18:3],
                                             // count [23:19]
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam int KXW  = (KEY_WIDTH > KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
   localparam int VXW  = (KEY_WIDTH > VALUE_W) ? KEY_WIDTH : VALUE_W;
   localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;

   state_type state_ff, state_in;

   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        slot_ff, slot_in;
   logic [AW-1:0]        wa_ff, wa_in;
   logic                 pend_ff, pend_in;
   logic                 done_ff, done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic                 hit_ff, hit_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [VALUE_W-1:0]   value_ff, value_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [KEY_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [KEY_WIDTH-1:0] ram_rd_data;

   logic [KXW-1:0]       key_ext;
   logic [VXW-1:0]       rd_ext;
   logic [CXW-1:0]       cnt_ext;
   logic [CMPW-1:0]      pos_cmp, cnt_cmp;
   logic [CW-1:0]        idx_inc, idx_dec;
   logic                 req_fire;
   logic                 found, equal;

   ssi_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign key_ext = KXW'(req_tdata[KEY_FIELD_W-1:0]);
   assign rd_ext  = VXW'(ram_rd_data);
   assign cnt_ext = CXW'(count_ff);
   assign pos_cmp = CMPW'(req_tdata[KEY_FIELD_W +: POS_W]);
   assign cnt_cmp = CMPW'(count_ff);
   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);

   // Result of the previous cycle's read during the scan
   assign found = pend_ff && (ram_rd_data >= key_ff);
   assign equal = pend_ff && (ram_rd_data == key_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      wa_in        = wa_ff;
      pend_in      = pend_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wa_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in   = req_tuser;
               key_in    = key_ext[KEY_WIDTH-1:0];
               pos_in    = AW'(req_tdata[KEY_FIELD_W +: POS_W]);
               hit_in    = 1'b0;
               status_in = STATUS_OK;
               value_in  = '0;
               idx_in    = '0;
               pend_in   = 1'b0;
               done_in   = 1'b0;
               case (req_tuser)
                  MODE_INSERT, MODE_MEMBER: state_in = S_SCAN;
                  MODE_READ: begin
                     if (pos_cmp < cnt_cmp) begin
                        state_in = S_READ;
                     end else begin
                        status_in = STATUS_RANGE;
                        state_in  = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_SCAN: begin
            if (found || idx_ff == count_ff) begin
               // stop at the first key not below the request, or past the end
               pend_in = 1'b0;
               slot_in = found ? idx_dec : count_ff;
               hit_in  = equal;
               if (mode_ff != MODE_INSERT || equal) begin
                  state_in = S_RESP;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_in = STATUS_FULL;
                  state_in  = S_RESP;
               end else if (!found) begin
                  state_in = S_PUT;
               end else begin
                  idx_in   = count_ff - CW'(1);
                  done_in  = 1'b0;
                  state_in = S_SHIFT;
               end
            end else begin
               ram_rd_en = 1'b1;
               idx_in    = idx_inc;
               pend_in   = 1'b1;
            end
         end

         S_SHIFT: begin
            // read entry i while writing the previous read into its slot above
            ram_wr_en = pend_ff;
            if (!done_ff) begin
               ram_rd_en = 1'b1;
               wa_in     = idx_inc[AW-1:0];
               pend_in   = 1'b1;
               if (idx_ff == slot_ff) begin
                  done_in = 1'b1;
               end else begin
                  idx_in = idx_dec;
               end
            end else begin
               pend_in  = 1'b0;
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_ff[AW-1:0];
            ram_wr_data = key_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_RESP;
         end

         S_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_ff;
            state_in    = S_FETCH;
         end

         S_FETCH: begin
            value_in = rd_ext[VALUE_W-1:0];
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.hit        = hit_ff;
               rsp_in.status     = status_ff;
               rsp_in.read_value = value_ff;
               rsp_in.count      = cnt_ext[COUNT_W-1:0];
               state_in          = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         slot_ff      <= '0;
         wa_ff        <= '0;
         pend_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         slot_ff      <= slot_in;
         wa_ff        <= wa_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("key count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1)))
      else $error("key count moved by more than one");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |-> count_ff == CW'(CAPACITY))
      else $error("full status while the set has room");

   a_shift_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && pend_ff && !done_ff) |-> wa_ff != idx_ff[AW-1:0])
      else $error("shift reads and writes the same entry");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for the sorted key set: a clocked driver and monitor, a key-set
// predictor and a queue of expected responses.
// Depends on ssi_pkg and the sorted_set_insert_lookup RTL.
module tb_top;
   import ssi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                CAPACITY    = 16;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int                RANDOM_ITEMS = 1025;

   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic [KEY_FIELD_W-1:0] key;
      logic [POS_W-1:0]       position;
   } key_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // key [15:0], position [19:16], zero [23:20]
   logic [REQ_USER_W-1:0] req_tuser = '0;   // mode [1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // hit [0], status [2:1], read_value [18:3],
                                            // count [23:19]

   key_request_type        pending_requests[$];
   rsp_type                expected_responses[$];
   key_request_type        active_request;
   logic [KEY_FIELD_W-1:0] stored_keys[$];

   // predictor copy of the store
   logic [KEY_FIELD_W-1:0] set_keys[CAPACITY];
   logic [COUNT_W-1:0]     set_count = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int failure_count      = 0;

   sorted_set_insert_lookup #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(KEY_FIELD_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type apply_to_key_set(key_request_type r);
      rsp_type res;
      bit      present;
      int      slot;
      int      i;
      res = '0;
      present = 1'b0;
      for (i = 0; i < set_count; i++)
         if (set_keys[i] == r.key) present = 1'b1;
      case (r.mode)
         MODE_INSERT: begin
            if (present) begin
               res.hit = 1'b1;
            end else if (set_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < set_count && set_keys[slot] < r.key) slot++;
               // shift the larger keys up by one
               for (i = set_count; i > slot; i--) set_keys[i] = set_keys[i-1];
               set_keys[slot] = r.key;
               set_count = set_count + 1'b1;
            end
         end
         MODE_MEMBER: res.hit = present;
         MODE_READ: begin
            if (r.position < set_count) res.read_value = set_keys[r.position];
            else res.status = STATUS_RANGE;
         end
         default: ;
      endcase
      res.count = set_count;
      return res;
   endfunction

   function automatic void compare_response(logic [RSP_DATA_W-1:0] data);
      rsp_type got;
      rsp_type want;
      got = rsp_type'(data);
      if (expected_responses.size() == 0) begin
         failure_count++;
         if (failure_count <= 10)
            $display("%0t: response with none outstanding: hit %0d status %0d value %h count %0d",
                     $realtime, got.hit, got.status, got.read_value, got.count);
         return;
      end
      want = expected_responses.pop_front();
      if (got.hit !== want.hit || got.status !== want.status ||
          got.read_value !== want.read_value || got.count !== want.count) begin
         failure_count++;
         if (failure_count <= 10)
            $display("%0t: mismatch: hit %0d/%0d status %0d/%0d value %h/%h count %0d/%0d",
                     $realtime, got.hit, want.hit, got.status, want.status,
                     got.read_value, want.read_value, got.count, want.count);
      end
   endfunction

   // driver: predict on acceptance, then offer the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            expected_responses.push_back(apply_to_key_set(active_request));
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               active_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W-KEY_FIELD_W-POS_W){1'b0}},
                              active_request.position, active_request.key};
               req_tuser  <= active_request.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) compare_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic queue_request(logic [MODE_W-1:0] mode, logic [KEY_FIELD_W-1:0] key,
                                logic [POS_W-1:0] position);
      key_request_type r;
      r.mode = mode;
      r.key = key;
      r.position = position;
      pending_requests.push_back(r);
   endtask

   function automatic logic [KEY_FIELD_W-1:0] fresh_key();
      logic [KEY_FIELD_W-1:0] k;
      bit                     clash;
      do begin
         k = KEY_FIELD_W'($urandom_range(16'hFFFF));
         clash = 1'b0;
         foreach (stored_keys[i])
            if (stored_keys[i] == k) clash = 1'b1;
      end while (clash);
      return k;
   endfunction

   function automatic key_request_type random_request();
      key_request_type r;
      int              pick;
      pick = $urandom_range(99);
      r.key = KEY_FIELD_W'($urandom_range(16'hFFFF));
      r.position = POS_W'($urandom_range(15));
      if (pick < 25) begin
         r.mode = MODE_INSERT;
         if ($urandom_range(1)) r.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (pick < 55) begin
         r.mode = MODE_MEMBER;
         if ($urandom_range(1)) r.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (pick < 92) begin
         r.mode = MODE_READ;
      end else begin
         r.mode = MODE_UNUSED;
      end
      return r;
   endfunction

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_random_phase(int items, int idle_pct, int stall_pct);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (items) pending_requests.push_back(random_request());
      wait_until_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idle_pct = 22;
      receiver_stall_pct = 59;

      // empty set, unused mode, both key extremes, duplicate, hit and miss
      queue_request(MODE_READ, 16'h1234, 4'd0);
      queue_request(MODE_UNUSED, 16'hFFFF, 4'hF);
      queue_request(MODE_INSERT, 16'hFFFF, 4'd0);
      queue_request(MODE_INSERT, 16'h0000, 4'hF);
      queue_request(MODE_INSERT, 16'h0000, 4'd0);
      queue_request(MODE_MEMBER, 16'hFFFF, 4'd0);
      queue_request(MODE_MEMBER, 16'h8000, 4'd0);
      queue_request(MODE_READ, 16'h0000, 4'd0);
      queue_request(MODE_READ, 16'h0000, 4'd1);
      queue_request(MODE_READ, 16'h0000, 4'd2);
      stored_keys.push_back(16'hFFFF);
      stored_keys.push_back(16'h0000);
      // fill the set in random order, then overflow it
      while (stored_keys.size() < CAPACITY) begin
         stored_keys.push_back(fresh_key());
         queue_request(MODE_INSERT, stored_keys[$], POS_W'($urandom_range(15)));
      end
      queue_request(MODE_INSERT, fresh_key(), 4'd0);
      queue_request(MODE_READ, 16'h0000, 4'hF);
      // hold off until every directed response is back
      wait_until_drained();

      queue_random_phase(RANDOM_ITEMS / 3, 22, 59);
      queue_random_phase(RANDOM_ITEMS / 3, 59, 22);
      queue_random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

      repeat (40) @(posedge clock);
      if (failure_count == 0 && expected_responses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
design/ssi_pkg.sv
design/ssi_ram.sv
design/sorted_set_insert_lookup.sv
bench/tb_top.sv
